FILE: sv/swat_pkg.sv
`default_nettype none

package swat_pkg;

    // Field widths
    localparam int RANGE_W    = 16;   // Q6.10 metres
    localparam int ANGLE_W    = 15;   // Q1.14 radians, unsigned result
    localparam int STEP_W     = 15;   // angle step register
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Defaults for the top level parameters
    localparam int DEF_MAX_SAMPLES  = 4096;
    localparam int DEF_CORDIC_STEPS = 16;

    // Angle constants, Q2.14
    localparam int HALF_PI_Q14 = 25736;
    localparam int PI_Q14      = 51472;
    localparam int TWO_PI_Q14  = 102944;

    // Start value of the rotation CORDIC (reciprocal of the gain limit), Q2.30
    localparam int GAIN_Q30 = 652032874;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESHOLD = 3'd4;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_MIN_RANGE      = 16'd0;
    localparam logic [15:0] RST_MAX_RANGE      = 16'd65535;
    localparam logic [15:0] RST_START_ANGLE    = 16'h9B78;   // -25736
    localparam logic [14:0] RST_ANGLE_STEP     = 15'd16;
    localparam logic [15:0] RST_NEAR_THRESHOLD = 16'd1;

    // atan(2^-i) in Q2.30, truncated
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd843314856;
            5'd1:    v = 32'd497837829;
            5'd2:    v = 32'd263043836;
            5'd3:    v = 32'd133525158;
            5'd4:    v = 32'd67021686;
            5'd5:    v = 32'd33543515;
            5'd6:    v = 32'd16775850;
            5'd7:    v = 32'd8388437;
            5'd8:    v = 32'd4194282;
            5'd9:    v = 32'd2097149;
            5'd10:   v = 32'd1048575;
            5'd11:   v = 32'd524287;
            5'd12:   v = 32'd262143;
            5'd13:   v = 32'd131071;
            5'd14:   v = 32'd65535;
            5'd15:   v = 32'd32767;
            5'd16:   v = 32'd16383;
            5'd17:   v = 32'd8191;
            5'd18:   v = 32'd4095;
            5'd19:   v = 32'd2047;
            5'd20:   v = 32'd1023;
            5'd21:   v = 32'd511;
            5'd22:   v = 32'd255;
            5'd23:   v = 32'd127;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: sv/scan_wall_angle_tracker.sv
`default_nettype none

// Wall angle tracker: takes one laser range sample per transaction in scan
// order and, on the sample flagged last, returns the largest angle seen
// between consecutive valid points of the scan (Q1.14 rad, 0 = parallel).
// One sample is worked on at a time and o_ready is high only when idle.
// A sample outside the range window goes straight to the done state. A valid
// sample runs a 15 x IW multiply, IW-1 compare-subtract steps that reduce the
// bearing modulo 2*pi (IW = clog2(MAX_SAMPLES)), and a rotation pass of the
// shared CORDIC; from the second valid point of a scan on, a second
// (vectoring) CORDIC pass follows unless a difference is under the
// threshold. The last sample also waits until the output register is free.
// Configuration writes are taken in any cycle.
module scan_wall_angle_tracker #(
    parameter int MAX_SAMPLES  = swat_pkg::DEF_MAX_SAMPLES,
    parameter int CORDIC_STEPS = swat_pkg::DEF_CORDIC_STEPS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [swat_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [swat_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // sample channel
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [swat_pkg::RANGE_W-1:0]     i_range,
    input  logic                             i_last_sample,
    // result channel
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [swat_pkg::ANGLE_W-1:0]     o_max_angle
);
    import swat_pkg::*;

    localparam int IW        = $clog2(MAX_SAMPLES);
    localparam int PW        = IW + STEP_W;          // step * index width
    localparam int RED_STEPS = PW - 16;              // 2*pi > 2^16
    localparam int STEP_MAX  = (CORDIC_STEPS > RED_STEPS) ? CORDIC_STEPS : RED_STEPS;
    localparam int CNTW      = $clog2(STEP_MAX);
    localparam int CW        = 34;                   // CORDIC datapath
    localparam int MW        = 48;                   // 16 x 32 product

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_BEAR, S_REDUCE, S_FOLD, S_ROTATE, S_MUL_X, S_MUL_Y,
        S_ROUND_Y, S_DIFF, S_VECTOR, S_ANGLE, S_DONE
    } t_state;

    // configuration
    logic [15:0]        r_min;
    logic [15:0]        r_max;
    logic signed [15:0] r_start;
    logic [14:0]        r_step;
    logic [15:0]        r_thr;

    // control and scan state
    t_state             r_state;
    logic [IW-1:0]      r_idx;
    logic               r_have_prev;
    logic [14:0]        r_greatest;
    logic               r_out_valid;
    logic [14:0]        r_out_angle;
    logic [CNTW-1:0]    r_cnt;

    // per-sample payload
    logic [15:0]        r_range;
    logic               r_last;
    logic               r_pt_ok;
    logic [15:0]        r_prev_x;
    logic signed [16:0] r_prev_y;
    logic [15:0]        r_cur_x;
    logic signed [16:0] r_cur_y;
    logic [PW-1:0]      r_red;
    logic signed [CW-1:0] r_x, r_y, r_z;
    logic               r_neg;
    logic [MW-1:0]      r_prod;
    logic [14:0]        r_ang;

    // shared multiplier
    logic [15:0]        mul_a;
    logic [31:0]        mul_b;
    logic [MW-1:0]      mul_p;
    logic signed [CW-1:0] abs_x, abs_y;

    // rounding of a product to Q6.10 with saturation
    logic [MW:0]        rnd_sum;
    logic [18:0]        rnd_q;
    logic [15:0]        rnd_mag;
    logic               y_is_neg;

    // shared CORDIC step
    logic signed [CW-1:0] xs, ys, at;
    logic               cw_sub;
    logic signed [CW-1:0] n_x, n_y, n_z;

    // bearing reduction and folding
    logic [PW-1:0]      red_div;
    logic [PW-1:0]      n_red;
    logic [17:0]        fold_t;
    logic [16:0]        fold_m;
    logic signed [17:0] fold_a;
    logic signed [17:0] fold_b;
    logic               fold_neg;

    // point differences
    logic signed [16:0] diff_x;
    logic signed [17:0] diff_y;
    logic [16:0]        dx;
    logic [17:0]        dy;

    // vectoring result
    logic signed [CW-1:0] vz_sum, vz_q;
    logic [14:0]        vz_ang;

    // multiplier operand select
    always_comb begin
        abs_x = r_x[CW-1] ? -r_x : r_x;
        abs_y = r_y[CW-1] ? -r_y : r_y;
        mul_a = r_range;
        mul_b = abs_x[31:0];
        case (r_state)
            S_MUL_BEAR: begin
                mul_a = 16'(r_step);
                mul_b = 32'(r_idx);
            end
            S_MUL_Y: mul_b = abs_y[31:0];
            default: mul_b = abs_x[31:0];
        endcase
        mul_p = 48'(mul_a) * 48'(mul_b);
    end

    // Q2.30 product back to Q6.10, halves up, saturated
    always_comb begin
        rnd_sum  = {1'b0, r_prod} + (MW+1)'(1 << 29);
        rnd_q    = rnd_sum[48:30];
        rnd_mag  = (rnd_q > 19'd65535) ? 16'hFFFF : rnd_q[15:0];
        y_is_neg = r_neg ? (r_y > 0) : r_y[CW-1];
    end

    // one CORDIC iteration, rotation or vectoring
    always_comb begin
        xs     = r_x >>> r_cnt;
        ys     = r_y >>> r_cnt;
        at     = CW'(atan_q30(5'(r_cnt)));
        cw_sub = (r_state == S_ROTATE) ? !r_z[CW-1] : !(r_y > 0);
        if (cw_sub) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - at;
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + at;
        end
    end

    // bearing: restoring reduction step, then wrap and fold to [-pi/2, pi/2]
    always_comb begin
        red_div = PW'(TWO_PI_Q14) << r_cnt;
        n_red   = (r_red >= red_div) ? (r_red - red_div) : r_red;
        fold_t  = 18'(r_red) + {{2{r_start[15]}}, r_start} + 18'(PI_Q14);
        fold_m  = (fold_t >= 18'(TWO_PI_Q14)) ? 17'(fold_t - 18'(TWO_PI_Q14))
                                              : fold_t[16:0];
        fold_a  = $signed({1'b0, fold_m}) - 18'sd51472;
        fold_neg = 1'b0;
        fold_b   = fold_a;
        if (fold_a > 18'sd25736) begin
            fold_b   = fold_a - 18'sd51472;
            fold_neg = 1'b1;
        end else if (fold_a < -18'sd25736) begin
            fold_b   = fold_a + 18'sd51472;
            fold_neg = 1'b1;
        end
    end

    // differences to the previous point
    always_comb begin
        diff_x = $signed({1'b0, r_cur_x}) - $signed({1'b0, r_prev_x});
        diff_y = 18'(r_cur_y) - 18'(r_prev_y);
        dx     = diff_x[16] ? 17'(-diff_x) : 17'(diff_x);
        dy     = diff_y[17] ? 18'(-diff_y) : 18'(diff_y);
    end

    // vectoring angle to Q2.14, halves up, clamped to [0, pi/2]
    always_comb begin
        vz_sum = r_z + CW'(32768);
        vz_q   = vz_sum >>> 16;
        if (vz_q[CW-1])
            vz_ang = 15'd0;
        else if (vz_q > CW'(HALF_PI_Q14))
            vz_ang = 15'(HALF_PI_Q14);
        else
            vz_ang = vz_q[14:0];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min       <= RST_MIN_RANGE;
            r_max       <= RST_MAX_RANGE;
            r_start     <= RST_START_ANGLE;
            r_step      <= RST_ANGLE_STEP;
            r_thr       <= RST_NEAR_THRESHOLD;
            r_idx       <= '0;
            r_have_prev <= 1'b0;
            r_greatest  <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            // configuration writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MIN_RANGE:      r_min   <= i_cfg_data;
                    CFG_MAX_RANGE:      r_max   <= i_cfg_data;
                    CFG_START_ANGLE:    r_start <= i_cfg_data;
                    CFG_ANGLE_STEP:     r_step  <= i_cfg_data[14:0];
                    CFG_NEAR_THRESHOLD: r_thr   <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && i_ready)
                r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_range <= i_range;
                        r_last  <= i_last_sample;
                        r_pt_ok <= (i_range > r_min) && (i_range < r_max);
                        r_state <= ((i_range > r_min) && (i_range < r_max)) ? S_MUL_BEAR
                                                                            : S_DONE;
                    end
                end
                S_MUL_BEAR: begin
                    r_red   <= PW'(mul_p);
                    r_cnt   <= CNTW'(RED_STEPS - 1);
                    r_state <= S_REDUCE;
                end
                S_REDUCE: begin
                    r_red <= n_red;
                    if (r_cnt == '0)
                        r_state <= S_FOLD;
                    else
                        r_cnt <= r_cnt - 1'b1;
                end
                S_FOLD: begin
                    r_x     <= CW'(GAIN_Q30);
                    r_y     <= '0;
                    r_z     <= CW'(fold_b) <<< 16;
                    r_neg   <= fold_neg;
                    r_cnt   <= '0;
                    r_state <= S_ROTATE;
                end
                S_ROTATE: begin
                    r_x <= n_x;
                    r_y <= n_y;
                    r_z <= n_z;
                    if (r_cnt == CNTW'(CORDIC_STEPS - 1))
                        r_state <= S_MUL_X;
                    else
                        r_cnt <= r_cnt + 1'b1;
                end
                S_MUL_X: begin
                    r_prod  <= mul_p;
                    r_state <= S_MUL_Y;
                end
                S_MUL_Y: begin
                    r_prod  <= mul_p;
                    r_cur_x <= rnd_mag;
                    r_state <= S_ROUND_Y;
                end
                S_ROUND_Y: begin
                    r_cur_y <= y_is_neg ? -$signed({1'b0, rnd_mag})
                                        : $signed({1'b0, rnd_mag});
                    r_state <= r_have_prev ? S_DIFF : S_DONE;
                end
                S_DIFF: begin
                    // counter cleared on a shortcut so S_ANGLE can tell the paths apart
                    if (dx < 17'(r_thr)) begin
                        r_ang   <= 15'(HALF_PI_Q14);
                        r_cnt   <= '0;
                        r_state <= S_ANGLE;
                    end else if (dy < 18'(r_thr)) begin
                        r_ang   <= 15'd0;
                        r_cnt   <= '0;
                        r_state <= S_ANGLE;
                    end else begin
                        r_x     <= $signed(CW'({dx, 12'd0}));
                        r_y     <= $signed(CW'({dy, 12'd0}));
                        r_z     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_VECTOR;
                    end
                end
                S_VECTOR: begin
                    r_x <= n_x;
                    r_y <= n_y;
                    r_z <= n_z;
                    if (r_cnt == CNTW'(CORDIC_STEPS - 1))
                        r_state <= S_ANGLE;
                    else
                        r_cnt <= r_cnt + 1'b1;
                end
                S_ANGLE: begin
                    // vectoring result is taken here when that pass ran
                    if (r_cnt == CNTW'(CORDIC_STEPS - 1)) begin
                        if (vz_ang > r_greatest)
                            r_greatest <= vz_ang;
                    end else if (r_ang > r_greatest) begin
                        r_greatest <= r_ang;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // last sample waits for the output register to empty
                    if (!(r_last && r_out_valid)) begin
                        if (r_last) begin
                            r_out_valid <= 1'b1;
                            r_out_angle <= r_greatest;
                            r_idx       <= '0;
                            r_have_prev <= 1'b0;
                            r_greatest  <= '0;
                        end else begin
                            if (r_pt_ok) begin
                                r_prev_x    <= r_cur_x;
                                r_prev_y    <= r_cur_y;
                                r_have_prev <= 1'b1;
                            end
                            if (r_idx == IW'(MAX_SAMPLES - 1))
                                r_idx <= '0;
                            else
                                r_idx <= r_idx + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_max_angle  = r_out_angle;

    // Samples are never taken back to back: o_ready is low after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("sample accepted while a sample was in work");

    // The kept maximum never leaves [0, pi/2]
    a_greatest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_greatest <= 15'(HALF_PI_Q14))
        else $error("greatest angle above pi/2");

    // Sample index wraps before it reaches the scan length
    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_idx) < 32'(MAX_SAMPLES))
        else $error("sample index out of range");

    // A result appears only when a last sample finishes
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE && $past(r_last)))
        else $error("result raised outside the end of a scan");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swat_pkg::*;

    localparam int  MAX_SAMPLES  = DEF_MAX_SAMPLES;
    localparam int  CORDIC_ITERS = (DEF_CORDIC_STEPS < 1)  ? 1 :
                                   (DEF_CORDIC_STEPS > 24) ? 24 : DEF_CORDIC_STEPS;
    localparam int  DRAIN_PAUSE  = 120;     // > worst per-sample latency
    localparam int  HOLD_CYCLES  = 1000;

    // Indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    // atan(2^-i), Q2.30
    localparam longint ARCTAN_Q30 [24] = '{
        843314856, 497837829, 263043836, 133525158,
        67021686,  33543515,  16775850,  8388437,
        4194282,   2097149,   1048575,   524287,
        262143,    131071,    65535,     32767,
        16383,     8191,      4095,      2047,
        1023,      511,       255,       127
    };

    typedef struct packed {
        logic [RANGE_W-1:0] range_q10;
        logic               last;
    } t_sample;

    // DUT ports
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_valid       = 1'b0;
    logic                  o_ready;
    logic [RANGE_W-1:0]    i_range       = '0;
    logic                  i_last_sample = 1'b0;
    logic                  o_valid;
    logic                  i_ready       = 1'b0;
    logic [ANGLE_W-1:0]    o_max_angle;

    // Register shadow, reset values
    logic        [15:0]        window_lo_q10  = RST_MIN_RANGE;
    logic        [15:0]        window_hi_q10  = RST_MAX_RANGE;
    logic signed [15:0]        start_q14      = RST_START_ANGLE;
    logic        [STEP_W-1:0]  step_q14       = RST_ANGLE_STEP;
    logic        [15:0]        near_q10       = RST_NEAR_THRESHOLD;

    // Tracker state
    logic        [11:0]        scan_pos       = '0;
    logic                      seen_point     = 1'b0;
    logic        [15:0]        last_x_q10     = '0;
    logic signed [16:0]        last_y_q10     = '0;
    logic        [ANGLE_W-1:0] steepest_q14   = '0;

    t_sample            pending_samples[$];
    logic [ANGLE_W-1:0] expected_angles[$];

    int send_idle_pct    = 31;
    int recv_idle_pct    = 77;
    int mismatches       = 0;
    int samples_accepted = 0;
    int angles_checked   = 0;
    int scans_queued     = 0;
    int reg_writes       = 0;
    int random_items     = 0;

    logic hold_arm   = 1'b0;
    logic hold_done  = 1'b0;
    int   hold_count = 0;

    scan_wall_angle_tracker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_range       (i_range),
        .i_last_sample (i_last_sample),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_max_angle   (o_max_angle)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Rotation CORDIC: bearing in Q2.14, cos/sin in Q2.30
    function automatic void bearing_cos_sin(input longint bearing,
                                            output longint cos_q30,
                                            output longint sin_q30);
        longint m, a, x, y, z, xs, ys;
        logic   flip;
        int     i;
        m = (bearing + PI_Q14) % TWO_PI_Q14;
        if (m < 0) m += TWO_PI_Q14;
        a = m - PI_Q14;
        flip = 1'b0;
        // fold into [-pi/2, pi/2], negating both outputs
        if (a > HALF_PI_Q14) begin
            a -= PI_Q14;
            flip = 1'b1;
        end else if (a < -HALF_PI_Q14) begin
            a += PI_Q14;
            flip = 1'b1;
        end
        x = GAIN_Q30;
        y = 0;
        z = a * 65536;
        for (i = 0; i < CORDIC_ITERS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ARCTAN_Q30[i];
            end else begin
                x += ys; y -= xs; z += ARCTAN_Q30[i];
            end
        end
        cos_q30 = flip ? -x : x;
        sin_q30 = flip ? -y : y;
    endfunction

    // r (Q6.10) times |f| (Q2.30), round half up, saturate
    function automatic longint scale_q10(input longint r, input longint f);
        longint p;
        if (f < 0) f = -f;
        p = (r * f + (longint'(1) << 29)) >>> 30;
        return (p > 65535) ? 65535 : p;
    endfunction

    // Vectoring CORDIC: atan(dy/dx) for nonnegative inputs, Q2.14
    function automatic longint slope_angle_q14(input longint dx, input longint dy);
        longint x, y, z, xs, ys, r;
        int     i;
        x = dx * 4096;
        y = dy * 4096;
        z = 0;
        for (i = 0; i < CORDIC_ITERS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += ARCTAN_Q30[i];
            end else begin
                x -= ys; y += xs; z -= ARCTAN_Q30[i];
            end
        end
        r = (z + 32768) >>> 16;
        if (r < 0) r = 0;
        if (r > HALF_PI_Q14) r = HALF_PI_Q14;
        return r;
    endfunction

    // One accepted sample: update the tracker, queue the scan result on the last one
    function automatic void track_sample(input logic [RANGE_W-1:0] range_q10, input logic last);
        longint bearing, c, s, x, y, dx, dy, ang;
        if (range_q10 > window_lo_q10 && range_q10 < window_hi_q10) begin
            bearing = longint'(start_q14) + longint'(step_q14) * longint'(scan_pos);
            bearing_cos_sin(bearing, c, s);
            x = scale_q10(range_q10, c);
            y = scale_q10(range_q10, s);
            if (s < 0) y = -y;
            if (seen_point) begin
                dx = x - longint'(last_x_q10);
                dy = y - longint'(last_y_q10);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                if (dx < longint'(near_q10))
                    ang = HALF_PI_Q14;
                else if (dy < longint'(near_q10))
                    ang = 0;
                else
                    ang = slope_angle_q14(dx, dy);
                if (ang > longint'(steepest_q14)) steepest_q14 = ang[ANGLE_W-1:0];
            end
            last_x_q10 = x[15:0];
            last_y_q10 = y[16:0];
            seen_point = 1'b1;
        end
        scan_pos = (scan_pos == MAX_SAMPLES - 1) ? '0 : scan_pos + 1'b1;
        if (last) begin
            expected_angles.push_back(steepest_q14);
            scan_pos     = '0;
            seen_point   = 1'b0;
            last_x_q10   = '0;
            last_y_q10   = '0;
            steepest_q14 = '0;
        end
    endfunction

    function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_MIN_RANGE:      window_lo_q10 = value;
            CFG_MAX_RANGE:      window_hi_q10 = value;
            CFG_START_ANGLE:    start_q14     = value;
            CFG_ANGLE_STEP:     step_q14      = value[STEP_W-1:0];
            CFG_NEAR_THRESHOLD: near_q10      = value;
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("MISMATCH @%0t: %s expected %0d got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // Sample driver
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid       <= 1'b1;
                i_range       <= pending_samples[0].range_q10;
                i_last_sample <= pending_samples[0].last;
                void'(pending_samples.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_arm && !hold_done) begin
            if (hold_count == HOLD_CYCLES - 1) hold_done <= 1'b1;
            hold_count <= hold_count + 1;
        end
    end

    // Result-side ready
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_ready <= 1'b0;
        else
            i_ready <= !(hold_arm && !hold_done) && ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------
    // Monitor: check results first, then predict from the new sample
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_angles.size() == 0) begin
                    report_mismatch("max angle with no scan pending", -1, o_max_angle);
                end else begin
                    if (o_max_angle !== expected_angles[0])
                        report_mismatch("max angle", expected_angles[0], o_max_angle);
                    void'(expected_angles.pop_front());
                    angles_checked++;
                end
            end
            if (i_valid && o_ready) begin
                track_sample(i_range, i_last_sample);
                samples_accepted++;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        set_register(idx, value);
        reg_writes++;
    endtask

    task automatic write_all(input int lo, input int hi, input int start, input int step,
                             input int near);
        write_reg(CFG_MIN_RANGE,      16'(lo));
        write_reg(CFG_MAX_RANGE,      16'(hi));
        write_reg(CFG_START_ANGLE,    16'(start));
        write_reg(CFG_ANGLE_STEP,     16'(step));
        write_reg(CFG_NEAR_THRESHOLD, 16'(near));
    endtask

    function automatic void add_sample(input logic [RANGE_W-1:0] range_q10, input logic last);
        t_sample s;
        s.range_q10 = range_q10;
        s.last      = last;
        pending_samples.push_back(s);
        if (last) scans_queued++;
    endfunction

    // Wait until every transaction is accepted and every result is back,
    // then let the block settle before touching registers
    task automatic drain_and_pause();
        while (pending_samples.size() != 0 || i_valid || expected_angles.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic pick_registers();
        int lo, hi, st, sp, nt;
        case ($urandom_range(9))
            0:       lo = 0;
            1:       lo = 65535;
            default: lo = $urandom_range(20000);
        endcase
        case ($urandom_range(9))
            0:       hi = 65535;
            1:       hi = 0;
            default: hi = $urandom_range(65535, 20001);
        endcase
        case ($urandom_range(7))
            0:       st = -HALF_PI_Q14;
            1:       st = HALF_PI_Q14;
            default: st = int'($urandom_range(2 * HALF_PI_Q14)) - HALF_PI_Q14;
        endcase
        case ($urandom_range(7))
            0:       sp = 0;
            1:       sp = HALF_PI_Q14;
            2, 3:    sp = $urandom_range(HALF_PI_Q14);
            default: sp = $urandom_range(400);
        endcase
        case ($urandom_range(9))
            0:       nt = 0;
            1:       nt = 65535;
            2:       nt = 1;
            default: nt = $urandom_range(512);
        endcase
        if ($urandom_range(5) == 0)
            write_reg(CFG_IDX_W'(CFG_UNUSED_LO + $urandom_range(2)),
                      CFG_DATA_W'($urandom_range(65535)));
        write_all(lo, hi, st, sp, nt);
    endtask

    // Scan of random samples: a slow walk along a surface or scattered
    // returns, with some samples off the window or on its bounds
    task automatic queue_random_scan(input int len);
        int lo, hi, v, c, k;
        logic walk;
        logic [RANGE_W-1:0] d;
        lo = int'(window_lo_q10) + 1;
        hi = int'(window_hi_q10) - 1;
        v = (lo <= hi) ? $urandom_range(hi, lo) : 0;
        walk = ($urandom_range(2) == 0);
        for (k = 0; k < len; k++) begin
            c = $urandom_range(99);
            if (lo > hi || c < 8) begin
                d = RANGE_W'($urandom_range(65535));
            end else if (c < 12) begin
                d = $urandom_range(1) ? window_lo_q10 : window_hi_q10;
            end else if (walk) begin
                v += int'($urandom_range(80)) - 40;
                if (v < lo) v = lo;
                if (v > hi) v = hi;
                d = v[RANGE_W-1:0];
            end else begin
                d = RANGE_W'($urandom_range(hi, lo));
            end
            add_sample(d, k == len - 1);
            random_items++;
        end
    endtask

    task automatic random_phase(input int target);
        int first, n;
        first = random_items;
        while (random_items - first < target) begin
            pick_registers();
            repeat ($urandom_range(8, 3)) begin
                n = ($urandom_range(4) == 0) ? $urandom_range(120, 25) : $urandom_range(24, 1);
                queue_random_scan(n);
            end
            drain_and_pause();
        end
    endtask

    task automatic directed_scans();
        // reset registers: extremes of the range field, both bounds
        add_sample(16'd0,      1'b0);
        add_sample(16'd65535,  1'b0);
        add_sample(16'd1,      1'b0);
        add_sample(16'd65534,  1'b0);
        add_sample(16'h5555,   1'b0);
        add_sample(16'hAAAA,   1'b1);
        // one valid point only: angle 0
        add_sample(16'd500,    1'b1);
        drain_and_pause();

        // writes to unmapped indexes must not disturb anything
        write_reg(CFG_UNUSED_HI, 16'hFFFF);
        write_reg(CFG_UNUSED_LO, 16'h0000);
        // empty window, sample on the bound
        write_reg(CFG_MIN_RANGE, 16'd1000);
        write_reg(CFG_MAX_RANGE, 16'd1000);
        add_sample(16'd1000, 1'b0);
        add_sample(16'd1001, 1'b1);
        drain_and_pause();

        // zero threshold, bearing 0: repeated point then dy zero
        write_all(0, 65535, 0, 0, 0);
        add_sample(16'd2000, 1'b0);
        add_sample(16'd2000, 1'b0);
        add_sample(16'd3000, 1'b1);
        drain_and_pause();

        // zero threshold, bearing pi/2: dx zero, dy not
        write_reg(CFG_START_ANGLE, 16'(HALF_PI_Q14));
        add_sample(16'd2000, 1'b0);
        add_sample(16'd3000, 1'b1);
        drain_and_pause();

        // widest threshold and step: bearings wrap around
        write_all(0, 65535, -HALF_PI_Q14, HALF_PI_Q14, 65535);
        add_sample(16'd40000, 1'b0);
        add_sample(16'd20000, 1'b0);
        add_sample(16'd65534, 1'b0);
        add_sample(16'd12345, 1'b1);
        drain_and_pause();

        write_all(0, 65535, HALF_PI_Q14 / 2, 1, 1);
        add_sample(16'd30000, 1'b0);
        add_sample(16'd30500, 1'b0);
        add_sample(16'd31000, 1'b1);
        drain_and_pause();
    endtask

    // Block fills up while results are held back
    task automatic receiver_hold_burst();
        @(posedge i_clk);
        hold_arm <= 1'b1;
        repeat (12) queue_random_scan($urandom_range(3, 1));
        drain_and_pause();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 31;
        recv_idle_pct = 77;
        directed_scans();
        random_phase(540);

        send_idle_pct = 77;
        recv_idle_pct = 31;
        random_phase(540);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        receiver_hold_burst();
        random_phase(530);

        $display("Covered %0d samples in %0d scans across %0d register writes;",
                 samples_accepted, scans_queued, reg_writes);
        $display("%0d scan angles checked, %0d mismatches.", angles_checked, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("TIMEOUT: %0d scan angles still outstanding", expected_angles.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
sv/swat_pkg.sv
sv/scan_wall_angle_tracker.sv
sim/tb_top.sv
